// File: src/sfgr_pkg.sv
// Shared types, constants and font table for the scaled glyph row generator.
package sfgr_pkg;

	localparam int MAX_SCALE   = 6;
	localparam int CELL_COLS   = 6;
	localparam int FONT_COLS   = 5;
	localparam int GLYPH_COUNT = 96;
	localparam int QUEUE_DEPTH = 4;

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);
	localparam int REP_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int COL_W   = $clog2(CELL_COLS);

	localparam logic [7:0] CODE_FIRST = 8'h20;
	localparam logic [7:0] CODE_LAST  = 8'h7F;
	localparam logic [2:0] ROW_TOP    = 3'd7;
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(CELL_COLS - 1);

	typedef enum logic [1:0] {
		CFG_FG    = 2'd0,
		CFG_BG    = 2'd1,
		CFG_SCALE = 2'd2,
		CFG_FLIP  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [2:0] row_index;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_color;
		logic        last_pixel;
	} out_item_t;

	// row word handed from the queue to the pixel emitter
	typedef struct packed {
		logic                 valid;
		logic [FONT_COLS-1:0] mask;
	} q2e_t;

	// column bytes in left-to-right order, leftmost column in the top byte
	localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0000503000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	// lit dots of one glyph row, bit c for font column c
	function automatic logic [FONT_COLS-1:0] row_mask(input logic [7:0] code,
	                                                  input logic [2:0] row,
	                                                  input logic       flip);
		logic [6:0]           glyph;
		logic [2:0]           grow;
		logic [39:0]          cols;
		logic [FONT_COLS-1:0] mask;
		glyph = 7'd0;
		if (code >= CODE_FIRST && code <= CODE_LAST) begin
			glyph = 7'(code - CODE_FIRST);
		end
		grow = flip ? (ROW_TOP - row) : row;
		cols = FONT_ROM[glyph];
		for (int c = 0; c < FONT_COLS; c++) begin
			mask[c] = cols[39 - 8 * c - 7 + int'(grow)];
		end
		return mask;
	endfunction

	// clamp the scale register into 1..MAX_SCALE
	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [2:0] raw);
		logic [SCALE_W-1:0] eff;
		if (raw == 3'd0) begin
			eff = SCALE_W'(1);
		end else if (int'(raw) > MAX_SCALE) begin
			eff = SCALE_W'(MAX_SCALE);
		end else begin
			eff = SCALE_W'(raw);
		end
		return eff;
	endfunction

endpackage

// File: src/sfgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/sfgr_queue.sv
// Row-word queue: RAM storage, pointers and a one-word read-ahead slot.
module sfgr_queue
	import sfgr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [FONT_COLS-1:0] wr_mask,
	output logic                 not_full,
	output q2e_t                 head,
	input  logic                 take
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rd_pend_q;
	logic                 slot_valid_q;
	logic                 issue;
	logic [FONT_COLS-1:0] rdata;

	// read ahead only into a free slot, or one that drains this cycle;
	// cnt_q excludes the word written now, so no read hits a word in flight
	assign issue = (cnt_q != '0) &&
	               (!(slot_valid_q || rd_pend_q) || (slot_valid_q && take));

	assign not_full   = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign head.valid = slot_valid_q;
	assign head.mask  = rdata;

	sfgr_ram #(
		.WIDTH (FONT_COLS),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_ptr_q),
		.wdata (wr_mask),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			cnt_q        <= '0;
			rd_pend_q    <= 1'b0;
			slot_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= PTR_W'((int'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			end
			if (issue) begin
				rd_ptr_q <= PTR_W'((int'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			end
			cnt_q     <= CNT_W'(int'(cnt_q) + int'(wr_en) - int'(issue));
			rd_pend_q <= issue;
			if (rd_pend_q) begin
				slot_valid_q <= 1'b1;
			end else if (take) begin
				slot_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/sfgr_emit.sv
// Pixel emitter: walks the six cell columns, repeating each one scale times.
module sfgr_emit
	import sfgr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  q2e_t               head,
	output logic               take,
	input  logic [15:0]        fg_color,
	input  logic [15:0]        bg_color,
	input  logic [SCALE_W-1:0] scale_eff,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	logic                 busy_q;
	logic [FONT_COLS-1:0] mask_q;
	logic [COL_W-1:0]     col_q;
	logic [REP_W-1:0]     rep_q;
	logic                 adv;
	logic                 rep_end;
	logic                 row_end;
	logic [CELL_COLS-1:0] cell_bits;

	assign rep_end   = (rep_q == REP_W'(int'(scale_eff) - 1));
	assign row_end   = rep_end && (col_q == LAST_COL);
	assign adv       = busy_q && out_ready;
	assign take      = head.valid && (!busy_q || (adv && row_end));
	// spacing column is never lit
	assign cell_bits = {{(CELL_COLS - FONT_COLS){1'b0}}, mask_q};

	assign out_valid            = busy_q;
	assign out_data.pixel_color = cell_bits[col_q] ? fg_color : bg_color;
	assign out_data.last_pixel  = row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			rep_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			col_q  <= '0;
			rep_q  <= '0;
		end else if (adv) begin
			if (row_end) begin
				busy_q <= 1'b0;
			end
			if (rep_end) begin
				rep_q <= '0;
				col_q <= COL_W'(int'(col_q) + 1);
			end else begin
				rep_q <= REP_W'(int'(rep_q) + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mask_q <= head.mask;
		end
	end

endmodule

// File: src/scaled_font_glyph_rasterizer.sv
// Top level of the scaled glyph row generator: config registers and datapath.
// Each accepted word (character code, row index) yields one glyph row of
// 6*scale RGB565 pixels, one pixel per cycle while out_ready is high, with
// last_pixel marking the final one; scale is glyph_scale clamped to 1..6, so
// a row holds 6 to 36 pixels. The font row is looked up on input and queued
// in a 4-word RAM, read one word ahead, so rows follow each other with no gap
// and input keeps flowing while a row is emitted. An accepted word goes through
// the RAM read and the read-ahead slot to the emitter. Configuration
// writes take effect at once and are always accepted; write them while idle.
module scaled_font_glyph_rasterizer
	import sfgr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]          fg_color_q;
	logic [15:0]          bg_color_q;
	logic [2:0]           glyph_scale_q;
	logic                 flip_rows_q;
	logic [SCALE_W-1:0]   scale_eff;
	logic                 wr_en;
	logic [FONT_COLS-1:0] wr_mask;
	logic                 not_full;
	logic                 take;
	q2e_t                 head;

	assign cfg_ready = 1'b1;
	assign in_ready  = not_full;
	assign wr_en     = in_valid && not_full;
	assign wr_mask   = row_mask(in_data.char_code, in_data.row_index, flip_rows_q);
	assign scale_eff = clamp_scale(glyph_scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q    <= 16'hFFFF;
			bg_color_q    <= 16'h0000;
			glyph_scale_q <= 3'd1;
			flip_rows_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FG: begin
					fg_color_q <= cfg_data;
				end
				CFG_BG: begin
					bg_color_q <= cfg_data;
				end
				CFG_SCALE: begin
					glyph_scale_q <= cfg_data[2:0];
				end
				CFG_FLIP: begin
					flip_rows_q <= cfg_data[0];
				end
			endcase
		end
	end

	sfgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_mask  (wr_mask),
		.not_full (not_full),
		.head     (head),
		.take     (take)
	);

	sfgr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.take      (take),
		.fg_color  (fg_color_q),
		.bg_color  (bg_color_q),
		.scale_eff (scale_eff),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: src/sfgr_checker.sv
// Port-level checks for the scaled glyph row generator, bound to the top level.
module sfgr_checker
	import sfgr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input in_item_t    in_data,
	input logic        out_valid,
	input logic        out_ready,
	input out_item_t   out_data,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input cfg_idx_t    cfg_index,
	input logic [15:0] cfg_data
);

	// a pending pixel is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the word was taken");

	// queue full means a row is being emitted
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while no pixel is pending");

	// nothing comes out right after reset
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("pixel present right after reset");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind scaled_font_glyph_rasterizer sfgr_checker u_sfgr_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for the glyph row generator: random traffic against a local font model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfgr_pkg::*;

	localparam int SCALE_CAP   = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 12;

	// five column bytes per glyph, leftmost column in the top byte, bit 0 = top row
	localparam logic [39:0] FONT_COLUMNS [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0000503000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_FG;
	logic [15:0] cfg_data  = '0;

	// local copy of the register file
	logic [15:0] fg_reg    = 16'hFFFF;
	logic [15:0] bg_reg    = 16'h0000;
	logic [2:0]  scale_reg = 3'd1;
	logic        flip_reg  = 1'b1;

	in_item_t  pending_rows[$];
	out_item_t expected_pixels[$];
	bit        send_gaps    = 1'b0;
	bit        sink_stalls  = 1'b0;
	bit        mismatch_seen = 1'b0;
	int        send_gap     = 0;
	int        sink_hold    = 0;
	int        quiet_cycles = 0;
	int        rows_queued  = 0;
	int        rows_taken   = 0;

	scaled_font_glyph_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short pauses, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// expand one glyph row into the pixels it must produce
	task automatic render_row(input in_item_t word);
		int          eff_scale;
		int          total;
		int          n;
		logic [6:0]  glyph;
		logic [2:0]  glyph_row;
		logic [7:0]  column;
		logic [15:0] color;
		out_item_t   px;
		eff_scale = (scale_reg == 3'd0) ? 1 :
		            (int'(scale_reg) > SCALE_CAP) ? SCALE_CAP : int'(scale_reg);
		total = 6 * eff_scale;
		glyph = 7'd0;
		if (word.char_code >= 8'h20 && word.char_code <= 8'h7F) begin
			glyph = 7'(word.char_code - 8'h20);
		end
		glyph_row = flip_reg ? (3'd7 - word.row_index) : word.row_index;
		n = 0;
		for (int col = 0; col < 6; col++) begin
			color = bg_reg;
			if (col < 5) begin
				column = FONT_COLUMNS[glyph][39 - 8 * col -: 8];
				if (column[glyph_row]) begin
					color = fg_reg;
				end
			end
			for (int rep = 0; rep < eff_scale; rep++) begin
				n++;
				px.pixel_color = color;
				px.last_pixel  = (n == total);
				expected_pixels.push_back(px);
			end
		end
	endtask

	task automatic check_pixel(input out_item_t got);
		out_item_t want;
		if (expected_pixels.size() == 0) begin
			$error("pixel with nothing expected: pixel_color=%h last_pixel=%b",
			       got.pixel_color, got.last_pixel);
			mismatch_seen = 1'b1;
			return;
		end
		want = expected_pixels.pop_front();
		if (got.pixel_color !== want.pixel_color) begin
			$error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
			mismatch_seen = 1'b1;
		end
		if (got.last_pixel !== want.last_pixel) begin
			$error("last_pixel: expected %b, got %b", want.last_pixel, got.last_pixel);
			mismatch_seen = 1'b1;
		end
	endtask

	// input driver: hold the word until taken, then pause or load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				render_row(in_data);
				rows_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_rows.size() != 0) begin
					in_data  <= pending_rows.pop_front();
					in_valid <= 1'b1;
					send_gap <= (send_gaps && $urandom_range(0, 99) < 35) ? gap_length() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_hold <= 0;
		end else begin
			if (out_valid && out_ready) begin
				check_pixel(out_data);
			end
			if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				out_ready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
				sink_hold <= gap_length() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// leaves cfg_valid high so back-to-back writes need no extra edge
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FG:    fg_reg = value;
			CFG_BG:    bg_reg = value;
			CFG_SCALE: scale_reg = value[2:0];
			CFG_FLIP:  flip_reg = value[0];
			default:   ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] fg, input logic [15:0] bg,
	                           input logic [15:0] scale_word, input logic [15:0] flip_word);
		write_reg(CFG_FG, fg);
		write_reg(CFG_BG, bg);
		write_reg(CFG_SCALE, scale_word);
		write_reg(CFG_FLIP, flip_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_row(input logic [7:0] code, input logic [2:0] row);
		in_item_t word;
		word.char_code = code;
		word.row_index = row;
		pending_rows.push_back(word);
		rows_queued++;
	endtask

	// wait until every queued word is taken and every pixel has come back
	task automatic drain();
		while (rows_taken != rows_queued || expected_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_color();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return 16'h0000;
		end
		if (r < 40) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	initial begin : stimulus
		logic [15:0] scale_word;
		logic [7:0]  code;
		int          r;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: white on black, scale 1, rows flipped
		queue_row(8'h20, 3'd3);
		queue_row(8'h21, 3'd1);
		queue_row(8'h41, 3'd7);
		queue_row(8'h41, 3'd0);
		queue_row(8'h7E, 3'd4);
		queue_row(8'h7F, 3'd5);
		queue_row(8'h00, 3'd2);
		queue_row(8'h1F, 3'd6);
		queue_row(8'h80, 3'd3);
		queue_row(8'hFF, 3'd5);
		drain();

		// scale zero acts as one, no flip, inverted colors
		load_config(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
		queue_row(8'h41, 3'd7);
		queue_row(8'h41, 3'd0);
		queue_row(8'h57, 3'd3);
		queue_row(8'h7F, 3'd2);
		queue_row(8'h23, 3'd6);
		drain();

		// scale seven clamps to six; upper data bits must be dropped
		load_config(16'hF800, 16'h07E0, 16'hFFFF, 16'hFFFF);
		queue_row(8'h42, 3'd2);
		queue_row(8'h80, 3'd1);
		queue_row(8'h7E, 3'd6);
		drain();

		load_config(16'hFFFF, 16'h0000, 16'h0006, 16'hFFFE);
		queue_row(8'h48, 3'd1);
		queue_row(8'h2F, 3'd4);
		queue_row(8'h5A, 3'd7);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			scale_word = 16'($urandom_range(0, 65535));
			scale_word[2:0] = ($urandom_range(0, 99) < 60) ? 3'($urandom_range(1, 3))
			                                                : 3'($urandom_range(0, 7));
			load_config(pick_color(), pick_color(), scale_word,
			            16'($urandom_range(0, 65535)));
			send_gaps   = (phase % 3) != 0;
			sink_stalls = (phase % 3) != 1;
			repeat ($urandom_range(11, 15)) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					code = 8'($urandom_range(8'h20, 8'h7F));
				end else if (r < 85) begin
					code = 8'($urandom_range(8'h00, 8'h1F));
				end else begin
					code = 8'($urandom_range(8'h80, 8'hFF));
				end
				queue_row(code, 3'($urandom_range(0, 7)));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (!mismatch_seen && expected_pixels.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
